@@ design/pngcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcs_pkg
// Chunk type codes, error codes, phase codes and controller commands shared
// by the PNG chunk sequence checker.
// ----------------------------------------------------------------------------
package pngcs_pkg;

  localparam int CFG_W  = 40;
  localparam int LEN_W  = 31;
  localparam int ERR_W  = 5;
  localparam int PH_W   = 3;
  localparam int CH_W   = 3;
  localparam int SEEN_W = 7;

  localparam logic [31:0] T_IHDR = 32'h49484452;
  localparam logic [31:0] T_IDAT = 32'h49444154;
  localparam logic [31:0] T_IEND = 32'h49454e44;
  localparam logic [31:0] T_PLTE = 32'h504c5445;
  localparam logic [31:0] T_TRNS = 32'h74524e53;
  localparam logic [31:0] T_CHRM = 32'h6348524d;
  localparam logic [31:0] T_GAMA = 32'h67414d41;
  localparam logic [31:0] T_ICCP = 32'h69434350;
  localparam logic [31:0] T_SBIT = 32'h73424954;
  localparam logic [31:0] T_SRGB = 32'h73524742;
  localparam logic [31:0] T_TEXT = 32'h74455874;
  localparam logic [31:0] T_ZTXT = 32'h7a545874;
  localparam logic [31:0] T_ITXT = 32'h69545874;
  localparam logic [31:0] T_BKGD = 32'h624b4744;
  localparam logic [31:0] T_HIST = 32'h68495354;
  localparam logic [31:0] T_PHYS = 32'h70485973;
  localparam logic [31:0] T_SPLT = 32'h73504c54;
  localparam logic [31:0] T_TIME = 32'h74494d45;

  // ancillary bit of the chunk type
  localparam int ANC_BIT = 29;

  // seen flag bit positions
  localparam int F_PLTE = 0;
  localparam int F_TRNS = 1;
  localparam int F_HIST = 2;
  localparam int F_BKGD = 3;
  localparam int F_IDAT = 4;
  localparam int F_ICCP = 5;
  localparam int F_SRGB = 6;

  localparam logic [PH_W-1:0] PH_WANT = 3'd0;
  localparam logic [PH_W-1:0] PH_ANC  = 3'd1;
  localparam logic [PH_W-1:0] PH_DATA = 3'd2;
  localparam logic [PH_W-1:0] PH_DONE = 3'd3;
  localparam logic [PH_W-1:0] PH_FAIL = 3'd4;

  localparam logic [ERR_W-1:0] E_OK         = 5'd0;
  localparam logic [ERR_W-1:0] E_NOT_IHDR   = 5'd1;
  localparam logic [ERR_W-1:0] E_IHDR_LEN   = 5'd2;
  localparam logic [ERR_W-1:0] E_ZERO_SIZE  = 5'd3;
  localparam logic [ERR_W-1:0] E_BIT_DEPTH  = 5'd4;
  localparam logic [ERR_W-1:0] E_COLOR      = 5'd5;
  localparam logic [ERR_W-1:0] E_COMPRESS   = 5'd6;
  localparam logic [ERR_W-1:0] E_FILTER     = 5'd7;
  localparam logic [ERR_W-1:0] E_INTERLACE  = 5'd8;
  localparam logic [ERR_W-1:0] E_TOO_LARGE  = 5'd9;
  localparam logic [ERR_W-1:0] E_DEPTH_KIND = 5'd10;
  localparam logic [ERR_W-1:0] E_PLTE_KIND  = 5'd11;
  localparam logic [ERR_W-1:0] E_PLTE_LATE  = 5'd12;
  localparam logic [ERR_W-1:0] E_PLTE_LEN   = 5'd13;
  localparam logic [ERR_W-1:0] E_TRNS_KIND  = 5'd14;
  localparam logic [ERR_W-1:0] E_TRNS_EARLY = 5'd15;
  localparam logic [ERR_W-1:0] E_TRNS_LONG  = 5'd16;
  localparam logic [ERR_W-1:0] E_TRNS_LEN   = 5'd17;
  localparam logic [ERR_W-1:0] E_TRNS_AGAIN = 5'd18;
  localparam logic [ERR_W-1:0] E_AFTER_PLTE = 5'd19;
  localparam logic [ERR_W-1:0] E_ICC_SRGB   = 5'd20;
  localparam logic [ERR_W-1:0] E_LENGTH     = 5'd21;
  localparam logic [ERR_W-1:0] E_HIST_EARLY = 5'd22;
  localparam logic [ERR_W-1:0] E_CRITICAL   = 5'd23;
  localparam logic [ERR_W-1:0] E_NO_IDAT    = 5'd24;
  localparam logic [ERR_W-1:0] E_NO_PLTE    = 5'd25;
  localparam logic [ERR_W-1:0] E_STOPPED    = 5'd26;

  typedef struct packed {
    logic capture;
    logic multiply;
    logic commit;
  } pngcs_cmd_t;

endpackage

@@ design/png_chunk_sequence_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_sequence_checker
// Checks PNG chunk order and length rules, one chunk header per beat.
// ----------------------------------------------------------------------------
// channel   dir  signals                         content
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  one chunk header
// m_axis    out  m_tvalid m_tready m_tdata m_tlast  one check result
// cfg       in   cfg_valid cfg_ready cfg_data      max_image_samples
//
// a header passes through capture, width times height multiply and rule
// evaluation into the result register; the next header is taken only after that.
// the evaluation waits while a previous result is still held.
// rst is synchronous; it restores the size limit and clears the sequencer and checker state.
// ----------------------------------------------------------------------------
module png_chunk_sequence_checker #(
  parameter int PALETTE_MAX = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // chunk_length, hdr_width, hdr_height, hdr_bit_depth, hdr_color_type,
  // hdr_compression, hdr_filter, hdr_interlace, one zero bit
  input  logic [135:0] s_tdata,
  // four-letter type tag of the chunk
  input  logic [31:0]  s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // error_code, phase_now, channel_count, image_data_start, four zero bits
  output logic [15:0]  m_tdata,
  // stream_end
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [39:0]  cfg_data
);

  pngcs_pkg::pngcs_cmd_t          cmd;
  logic [pngcs_pkg::ERR_W-1:0]    res_err;
  logic [pngcs_pkg::PH_W-1:0]     res_phase;
  logic [pngcs_pkg::CH_W-1:0]     res_channels;
  logic                           res_start;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {4'b0000, res_start, res_channels, res_phase, res_err};

  pngcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  pngcs_dp #(
    .PALETTE_MAX (PALETTE_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid),
    .cfg_value    (cfg_data),
    .in_type      (s_tuser),
    .in_len       (s_tdata[30:0]),
    .in_width     (s_tdata[62:31]),
    .in_height    (s_tdata[94:63]),
    .in_depth     (s_tdata[102:95]),
    .in_color     (s_tdata[110:103]),
    .in_compress  (s_tdata[118:111]),
    .in_filter    (s_tdata[126:119]),
    .in_interlace (s_tdata[134:127]),
    .res_err      (res_err),
    .res_phase    (res_phase),
    .res_channels (res_channels),
    .res_start    (res_start),
    .res_end      (m_tlast)
  );

endmodule

@@ design/pngcs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcs_ctrl
// Sequencer: capture a header beat, multiply, evaluate into the result
// register once it is free.
// ----------------------------------------------------------------------------
module pngcs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pngcs_pkg::pngcs_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL
  } state_t;

  state_t state;
  logic   commit;

  assign in_ready     = (state == ST_IDLE);
  assign commit       = (state == ST_EVAL) && (!out_valid || out_ready);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.multiply = (state == ST_MUL);
  assign cmd.commit   = commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_MUL;
        end
        ST_MUL: state <= ST_EVAL;
        ST_EVAL: begin
          if (commit) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ design/pngcs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngcs_dp
// Datapath: captured header, size product, rule evaluation, checker state
// and result register.
// ----------------------------------------------------------------------------
module pngcs_dp #(
  parameter int PALETTE_MAX = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pngcs_pkg::pngcs_cmd_t         cmd,
  input  logic                          cfg_we,
  input  logic [pngcs_pkg::CFG_W-1:0]   cfg_value,
  input  logic [31:0]                   in_type,
  input  logic [pngcs_pkg::LEN_W-1:0]   in_len,
  input  logic [31:0]                   in_width,
  input  logic [31:0]                   in_height,
  input  logic [7:0]                    in_depth,
  input  logic [7:0]                    in_color,
  input  logic [7:0]                    in_compress,
  input  logic [7:0]                    in_filter,
  input  logic [7:0]                    in_interlace,
  output logic [pngcs_pkg::ERR_W-1:0]   res_err,
  output logic [pngcs_pkg::PH_W-1:0]    res_phase,
  output logic [pngcs_pkg::CH_W-1:0]    res_channels,
  output logic                          res_start,
  output logic                          res_end
);

  localparam int PAL_W     = $clog2(PALETTE_MAX + 1);
  localparam int PLEN_MAX  = PALETTE_MAX * 3;
  localparam int PLEN_W    = $clog2(PLEN_MAX + 1);
  // floor(x / 3) as (x * 683) >> 11, exact for x up to 768
  localparam int RECIP_W   = PLEN_W + 10;
  localparam int PROD_W    = 64;
  localparam int SCALE_W   = PROD_W + 2;

  localparam logic [pngcs_pkg::CFG_W-1:0] CFG_RESET = 40'd1073741824;

  logic [pngcs_pkg::CFG_W-1:0]  max_samples;
  logic [31:0]                  c_type, c_width, c_height;
  logic [pngcs_pkg::LEN_W-1:0]  c_len;
  logic [7:0]                   c_depth, c_color, c_compress, c_filter, c_interlace;
  logic [PROD_W-1:0]            prod;

  logic [pngcs_pkg::PH_W-1:0]   phase, phase_next;
  logic [pngcs_pkg::SEEN_W-1:0] seen, seen_next;
  logic [2:0]                   kind, kind_next;
  logic [pngcs_pkg::CH_W-1:0]   chans, chans_next;
  logic [PAL_W-1:0]             pal, pal_next;
  logic [pngcs_pkg::ERR_W-1:0]  err;
  logic                         start, fin;

  logic [pngcs_pkg::CH_W-1:0]   ihdr_ch;
  logic [SCALE_W-1:0]           scaled;
  logic                         too_large;
  logic [PLEN_W-1:0]            plen;
  logic [RECIP_W-1:0]           recip;
  logic [PAL_W-1:0]             pquot;
  logic [PLEN_W+1:0]            ptimes3;
  logic                         plen_bad;
  logic [pngcs_pkg::LEN_W-1:0]  sbit_need, bkgd_need;
  logic [pngcs_pkg::ERR_W-1:0]  common_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= CFG_RESET;
    end else if (cfg_we) begin
      max_samples <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_type      <= in_type;
      c_len       <= in_len;
      c_width     <= in_width;
      c_height    <= in_height;
      c_depth     <= in_depth;
      c_color     <= in_color;
      c_compress  <= in_compress;
      c_filter    <= in_filter;
      c_interlace <= in_interlace;
    end
    if (cmd.multiply) prod <= PROD_W'(c_width) * PROD_W'(c_height);
  end

  // w * h > floor(max / ch) is the same as w * h * ch > max
  always_comb begin
    case (c_color)
      8'd0:    ihdr_ch = 3'd1;
      8'd4:    ihdr_ch = 3'd2;
      8'd6:    ihdr_ch = 3'd4;
      default: ihdr_ch = 3'd3;
    endcase
    case (ihdr_ch)
      3'd1:    scaled = SCALE_W'(prod);
      3'd2:    scaled = {1'b0, prod, 1'b0};
      3'd4:    scaled = {prod, 2'b00};
      default: scaled = SCALE_W'(prod) + {1'b0, prod, 1'b0};
    endcase
    too_large = scaled > SCALE_W'(max_samples);
  end

  always_comb begin
    plen     = c_len[PLEN_W-1:0];
    recip    = RECIP_W'(plen) * RECIP_W'(683);
    pquot    = PAL_W'(recip >> 11);
    ptimes3  = (PLEN_W+2)'(pquot) + (PLEN_W+2)'({pquot, 1'b0});
    plen_bad = (c_len > pngcs_pkg::LEN_W'(PLEN_MAX)) || (ptimes3 != (PLEN_W+2)'(plen));
  end

  always_comb begin
    case (kind)
      3'd0:         sbit_need = 31'd1;
      3'd2, 3'd3:   sbit_need = 31'd3;
      3'd4:         sbit_need = 31'd2;
      default:      sbit_need = 31'd4;
    endcase
    case (kind)
      3'd0, 3'd4:   bkgd_need = 31'd2;
      3'd2, 3'd6:   bkgd_need = 31'd6;
      default:      bkgd_need = 31'd1;
    endcase
    case (c_type)
      pngcs_pkg::T_TEXT:
        common_err = (c_len < 31'd2) ? pngcs_pkg::E_LENGTH : pngcs_pkg::E_OK;
      pngcs_pkg::T_ZTXT:
        common_err = (c_len < 31'd3) ? pngcs_pkg::E_LENGTH : pngcs_pkg::E_OK;
      pngcs_pkg::T_ITXT:
        common_err = (c_len < 31'd6) ? pngcs_pkg::E_LENGTH : pngcs_pkg::E_OK;
      pngcs_pkg::T_TIME:
        common_err = (c_len != 31'd7) ? pngcs_pkg::E_LENGTH : pngcs_pkg::E_OK;
      default:
        common_err = c_type[pngcs_pkg::ANC_BIT] ? pngcs_pkg::E_OK : pngcs_pkg::E_CRITICAL;
    endcase
  end

  always_comb begin
    err        = pngcs_pkg::E_OK;
    phase_next = phase;
    seen_next  = seen;
    kind_next  = kind;
    chans_next = chans;
    pal_next   = pal;
    start      = 1'b0;
    fin        = 1'b0;
    if (phase >= pngcs_pkg::PH_DONE) begin
      err = pngcs_pkg::E_STOPPED;
    end else if (phase == pngcs_pkg::PH_WANT) begin
      if (c_type != pngcs_pkg::T_IHDR) err = pngcs_pkg::E_NOT_IHDR;
      else if (c_len != 31'd13) err = pngcs_pkg::E_IHDR_LEN;
      else if (c_width == 32'd0 || c_height == 32'd0) err = pngcs_pkg::E_ZERO_SIZE;
      else if (!(c_depth inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16}))
        err = pngcs_pkg::E_BIT_DEPTH;
      else if (!(c_color inside {8'd0, 8'd2, 8'd3, 8'd4, 8'd6})) err = pngcs_pkg::E_COLOR;
      else if (c_compress != 8'd0) err = pngcs_pkg::E_COMPRESS;
      else if (c_filter != 8'd0) err = pngcs_pkg::E_FILTER;
      else if (c_interlace > 8'd1) err = pngcs_pkg::E_INTERLACE;
      else if (too_large) err = pngcs_pkg::E_TOO_LARGE;
      else if ((c_color inside {8'd2, 8'd4, 8'd6}) && c_depth < 8'd8)
        err = pngcs_pkg::E_DEPTH_KIND;
      else if (c_color == 8'd3 && c_depth == 8'd16) err = pngcs_pkg::E_DEPTH_KIND;
      else begin
        kind_next  = c_color[2:0];
        chans_next = ihdr_ch;
        phase_next = pngcs_pkg::PH_ANC;
      end
    end else if (c_type == pngcs_pkg::T_IDAT) begin
      if (kind == 3'd3 && !seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_NO_PLTE;
      else begin
        seen_next[pngcs_pkg::F_IDAT] = 1'b1;
        if (phase == pngcs_pkg::PH_ANC) begin
          phase_next = pngcs_pkg::PH_DATA;
          start      = 1'b1;
        end
      end
    end else if (c_type == pngcs_pkg::T_IEND) begin
      if (!seen[pngcs_pkg::F_IDAT]) err = pngcs_pkg::E_NO_IDAT;
      else if (c_len != 31'd0) err = pngcs_pkg::E_LENGTH;
      else begin
        phase_next = pngcs_pkg::PH_DONE;
        fin        = 1'b1;
      end
    end else if (phase == pngcs_pkg::PH_ANC) begin
      case (c_type)
        pngcs_pkg::T_PLTE: begin
          if (kind == 3'd0 || kind == 3'd4) err = pngcs_pkg::E_PLTE_KIND;
          else if (seen[pngcs_pkg::F_TRNS] || seen[pngcs_pkg::F_HIST] ||
                   seen[pngcs_pkg::F_BKGD]) err = pngcs_pkg::E_PLTE_LATE;
          else if (plen_bad) err = pngcs_pkg::E_PLTE_LEN;
          else begin
            pal_next = pquot;
            seen_next[pngcs_pkg::F_PLTE] = 1'b1;
          end
        end
        pngcs_pkg::T_TRNS: begin
          if (kind == 3'd4 || kind == 3'd6) err = pngcs_pkg::E_TRNS_KIND;
          else if (seen[pngcs_pkg::F_TRNS]) err = pngcs_pkg::E_TRNS_AGAIN;
          else if (kind == 3'd3) begin
            if (!seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_TRNS_EARLY;
            else if (c_len > pngcs_pkg::LEN_W'(pal)) err = pngcs_pkg::E_TRNS_LONG;
            else begin
              chans_next = 3'd4;
              seen_next[pngcs_pkg::F_TRNS] = 1'b1;
            end
          end else if (c_len != {27'd0, chans, 1'b0}) err = pngcs_pkg::E_TRNS_LEN;
          else begin
            chans_next = chans + 3'd1;
            seen_next[pngcs_pkg::F_TRNS] = 1'b1;
          end
        end
        pngcs_pkg::T_CHRM: begin
          if (seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_AFTER_PLTE;
          else if (c_len != 31'd32) err = pngcs_pkg::E_LENGTH;
        end
        pngcs_pkg::T_GAMA: begin
          if (seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_AFTER_PLTE;
          else if (c_len != 31'd4) err = pngcs_pkg::E_LENGTH;
        end
        pngcs_pkg::T_ICCP: begin
          if (seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_AFTER_PLTE;
          else if (seen[pngcs_pkg::F_SRGB]) err = pngcs_pkg::E_ICC_SRGB;
          else if (c_len < 31'd4) err = pngcs_pkg::E_LENGTH;
          else seen_next[pngcs_pkg::F_ICCP] = 1'b1;
        end
        pngcs_pkg::T_SBIT: begin
          if (seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_AFTER_PLTE;
          else if (c_len != sbit_need) err = pngcs_pkg::E_LENGTH;
        end
        pngcs_pkg::T_SRGB: begin
          if (seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_AFTER_PLTE;
          else if (seen[pngcs_pkg::F_ICCP]) err = pngcs_pkg::E_ICC_SRGB;
          else if (c_len != 31'd1) err = pngcs_pkg::E_LENGTH;
          else seen_next[pngcs_pkg::F_SRGB] = 1'b1;
        end
        pngcs_pkg::T_BKGD: begin
          if (c_len != bkgd_need) err = pngcs_pkg::E_LENGTH;
          else seen_next[pngcs_pkg::F_BKGD] = 1'b1;
        end
        pngcs_pkg::T_HIST: begin
          if (!seen[pngcs_pkg::F_PLTE]) err = pngcs_pkg::E_HIST_EARLY;
          else if (c_len < 31'd2) err = pngcs_pkg::E_LENGTH;
          else seen_next[pngcs_pkg::F_HIST] = 1'b1;
        end
        pngcs_pkg::T_PHYS: begin
          if (c_len != 31'd9) err = pngcs_pkg::E_LENGTH;
        end
        pngcs_pkg::T_SPLT: begin
          if (c_len < 31'd9) err = pngcs_pkg::E_LENGTH;
        end
        default: err = common_err;
      endcase
    end else begin
      err = common_err;
    end
    // a failing beat leaves everything but the phase untouched
    if (err != pngcs_pkg::E_OK && err != pngcs_pkg::E_STOPPED) begin
      phase_next = pngcs_pkg::PH_FAIL;
      seen_next  = seen;
      kind_next  = kind;
      chans_next = chans;
      pal_next   = pal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pngcs_pkg::PH_WANT;
      seen  <= '0;
      kind  <= '0;
      chans <= '0;
      pal   <= '0;
    end else if (cmd.commit) begin
      phase <= phase_next;
      seen  <= seen_next;
      kind  <= kind_next;
      chans <= chans_next;
      pal   <= pal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_err      <= err;
      res_phase    <= phase_next;
      res_channels <= chans_next;
      res_start    <= start;
      res_end      <= fin;
    end
  end

endmodule

@@ tb/sv/tb_png_chunk_sequence_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_chunk_sequence_checker
// Drives one PNG chunk stream through the checker: a directed table that
// walks an indexed-colour image through the header and data phases, then
// random data-phase chunks, then a stopping chunk and stopped traffic. Each
// result beat is compared field by field with a local model of the rules.
// ----------------------------------------------------------------------------
module tb_png_chunk_sequence_checker;
  import pngcs_pkg::*;

  localparam int PALETTE_MAX = 256;

  typedef struct {
    logic [31:0] ctype;
    logic [30:0] len;
    logic [31:0] w;
    logic [31:0] h;
    logic [7:0]  bd;
    logic [7:0]  ct;
    logic [7:0]  cmp;
    logic [7:0]  flt;
    logic [7:0]  il;
  } chunk_t;

  typedef struct {
    logic [4:0] err;
    logic [2:0] ph;
    logic [2:0] ch;
    logic       start;
    logic       fin;
    bit         typed;
    logic [4:0] typed_err;
  } verdict_t;

  typedef struct {
    chunk_t     c;
    bit         typed;
    logic [4:0] err;
  } row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic [31:0]  s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;
  logic         m_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [39:0]  cfg_data;

  png_chunk_sequence_checker DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // model state
  logic [39:0] mdl_limit;
  logic [2:0]  mdl_phase;
  logic [6:0]  mdl_seen;
  logic [2:0]  mdl_kind;
  logic [4:0]  mdl_depth;
  logic [2:0]  mdl_chan;
  logic [8:0]  mdl_pal;

  verdict_t pending_q[$];
  row_t     dir_rows[$];
  int       fails;
  bit       quiet;
  logic     hold_rx;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic logic [4:0] ihdr_rule(chunk_t c);
    logic [2:0]  ch;
    logic [63:0] area;
    if (c.len != 31'd13) return E_IHDR_LEN;
    if (c.w == 0 || c.h == 0) return E_ZERO_SIZE;
    if (!(c.bd inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16})) return E_BIT_DEPTH;
    if (!(c.ct inside {8'd0, 8'd2, 8'd3, 8'd4, 8'd6})) return E_COLOR;
    if (c.cmp != 0) return E_COMPRESS;
    if (c.flt != 0) return E_FILTER;
    if (c.il > 8'd1) return E_INTERLACE;
    ch = (c.ct == 0) ? 3'd1 : (c.ct == 4) ? 3'd2 : (c.ct == 6) ? 3'd4 : 3'd3;
    area = {32'd0, c.w} * {32'd0, c.h};
    if (area > {24'd0, mdl_limit / ch}) return E_TOO_LARGE;
    if ((c.ct == 2 || c.ct == 4 || c.ct == 6) && c.bd < 8) return E_DEPTH_KIND;
    if (c.ct == 3 && c.bd == 16) return E_DEPTH_KIND;
    mdl_kind  = c.ct[2:0];
    mdl_depth = c.bd[4:0];
    mdl_chan  = ch;
    return E_OK;
  endfunction

  function automatic logic [4:0] text_rule(logic [31:0] t, logic [30:0] len);
    case (t)
      T_TEXT: return (len < 2) ? E_LENGTH : E_OK;
      T_ZTXT: return (len < 3) ? E_LENGTH : E_OK;
      T_ITXT: return (len < 6) ? E_LENGTH : E_OK;
      T_TIME: return (len != 7) ? E_LENGTH : E_OK;
      default: return t[ANC_BIT] ? E_OK : E_CRITICAL;
    endcase
  endfunction

  function automatic logic [4:0] header_rule(logic [31:0] t, logic [30:0] len);
    int need;
    case (t)
      T_PLTE: begin
        if (mdl_kind == 0 || mdl_kind == 4) return E_PLTE_KIND;
        if (mdl_seen[F_TRNS] || mdl_seen[F_HIST] || mdl_seen[F_BKGD]) return E_PLTE_LATE;
        if (len > PALETTE_MAX * 3 || len % 3 != 0) return E_PLTE_LEN;
        mdl_pal = 9'(len / 3);
        mdl_seen[F_PLTE] = 1'b1;
        return E_OK;
      end
      T_TRNS: begin
        if (mdl_kind == 4 || mdl_kind == 6) return E_TRNS_KIND;
        if (mdl_seen[F_TRNS]) return E_TRNS_AGAIN;
        if (mdl_kind == 3) begin
          if (!mdl_seen[F_PLTE]) return E_TRNS_EARLY;
          if (len > mdl_pal) return E_TRNS_LONG;
          mdl_chan = 3'd4;
        end else begin
          if (len != 2 * mdl_chan) return E_TRNS_LEN;
          mdl_chan = mdl_chan + 3'd1;
        end
        mdl_seen[F_TRNS] = 1'b1;
        return E_OK;
      end
      T_CHRM: begin
        if (mdl_seen[F_PLTE]) return E_AFTER_PLTE;
        return (len != 32) ? E_LENGTH : E_OK;
      end
      T_GAMA: begin
        if (mdl_seen[F_PLTE]) return E_AFTER_PLTE;
        return (len != 4) ? E_LENGTH : E_OK;
      end
      T_ICCP: begin
        if (mdl_seen[F_PLTE]) return E_AFTER_PLTE;
        if (mdl_seen[F_SRGB]) return E_ICC_SRGB;
        if (len < 4) return E_LENGTH;
        mdl_seen[F_ICCP] = 1'b1;
        return E_OK;
      end
      T_SBIT: begin
        if (mdl_seen[F_PLTE]) return E_AFTER_PLTE;
        need = (mdl_kind == 0) ? 1 : (mdl_kind == 2 || mdl_kind == 3) ? 3 :
               (mdl_kind == 4) ? 2 : 4;
        return (len != need) ? E_LENGTH : E_OK;
      end
      T_SRGB: begin
        if (mdl_seen[F_PLTE]) return E_AFTER_PLTE;
        if (mdl_seen[F_ICCP]) return E_ICC_SRGB;
        if (len != 1) return E_LENGTH;
        mdl_seen[F_SRGB] = 1'b1;
        return E_OK;
      end
      T_BKGD: begin
        need = (mdl_kind == 0 || mdl_kind == 4) ? 2 :
               (mdl_kind == 2 || mdl_kind == 6) ? 6 : 1;
        if (len != need) return E_LENGTH;
        mdl_seen[F_BKGD] = 1'b1;
        return E_OK;
      end
      T_HIST: begin
        if (!mdl_seen[F_PLTE]) return E_HIST_EARLY;
        if (len < 2) return E_LENGTH;
        mdl_seen[F_HIST] = 1'b1;
        return E_OK;
      end
      T_PHYS: return (len != 9) ? E_LENGTH : E_OK;
      T_SPLT: return (len < 9) ? E_LENGTH : E_OK;
      default: return text_rule(t, len);
    endcase
  endfunction

  function automatic verdict_t judge_chunk(chunk_t c);
    verdict_t v;
    v = '{default: '0};
    if (mdl_phase >= PH_DONE) begin
      v.err = E_STOPPED;
    end else if (mdl_phase == PH_WANT) begin
      v.err = (c.ctype != T_IHDR) ? E_NOT_IHDR : ihdr_rule(c);
      if (v.err == E_OK) mdl_phase = PH_ANC;
    end else if (c.ctype == T_IDAT) begin
      if (mdl_kind == 3 && !mdl_seen[F_PLTE]) begin
        v.err = E_NO_PLTE;
      end else begin
        mdl_seen[F_IDAT] = 1'b1;
        if (mdl_phase == PH_ANC) begin
          mdl_phase = PH_DATA;
          v.start = 1'b1;
        end
      end
    end else if (c.ctype == T_IEND) begin
      if (!mdl_seen[F_IDAT]) v.err = E_NO_IDAT;
      else if (c.len != 0) v.err = E_LENGTH;
      else begin
        mdl_phase = PH_DONE;
        v.fin = 1'b1;
      end
    end else if (mdl_phase == PH_ANC) begin
      v.err = header_rule(c.ctype, c.len);
    end else begin
      v.err = text_rule(c.ctype, c.len);
    end
    if (v.err != E_OK && v.err != E_STOPPED) mdl_phase = PH_FAIL;
    v.ph = mdl_phase;
    v.ch = mdl_chan;
    return v;
  endfunction

  function automatic chunk_t mk(logic [31:0] t, logic [30:0] len);
    chunk_t c;
    c.ctype = t;
    c.len = len;
    c.w = $urandom;
    c.h = $urandom;
    c.bd = 8'($urandom);
    c.ct = 8'($urandom);
    c.cmp = 8'($urandom);
    c.flt = 8'($urandom);
    c.il = 8'($urandom);
    return c;
  endfunction

  task automatic add_row(chunk_t c, bit typed, logic [4:0] err);
    row_t r;
    r.c = c;
    r.typed = typed;
    r.err = err;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic send_chunk(chunk_t c, bit typed = 0, logic [4:0] terr = E_OK);
    verdict_t v;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, c.il, c.flt, c.cmp, c.ct, c.bd, c.h, c.w, c.len};
    s_tuser  <= c.ctype;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = judge_chunk(c);
    v.typed = typed;
    v.typed_err = terr;
    pending_q.insert(pending_q.size(), v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic write_limit(logic [39:0] val);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mdl_limit = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic chunk_t data_chunk();
    logic [31:0] t;
    logic [30:0] len;
    len = 31'($urandom);
    case ($urandom_range(0, 5))
      0: t = T_IDAT;
      1: begin t = T_TEXT; if (len < 2) len = 2; end
      2: begin t = T_ZTXT; if (len < 3) len = 3; end
      3: begin t = T_ITXT; if (len < 6) len = 6; end
      4: begin t = T_TIME; len = 7; end
      default: begin
        // unknown ancillary type, skipped in the data phase
        t = $urandom | (32'd1 << ANC_BIT);
        if (t == T_TEXT || t == T_ZTXT || t == T_ITXT || t == T_TIME) t = T_GAMA;
      end
    endcase
    return mk(t, len);
  endfunction

  // result side: random stall bursts, long hold-off on request
  initial begin
    int stall;
    verdict_t v;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result beat %h last %b", $realtime, m_tdata, m_tlast);
          fails++;
        end else begin
          v = pending_q.pop_front();
          if (m_tdata[4:0] !== v.err) begin
            $display("%0t error_code exp %0d got %0d", $realtime, v.err, m_tdata[4:0]);
            fails++;
          end
          if (v.typed && m_tdata[4:0] !== v.typed_err) begin
            $display("%0t table error_code exp %0d got %0d", $realtime, v.typed_err,
                     m_tdata[4:0]);
            fails++;
          end
          if (m_tdata[7:5] !== v.ph) begin
            $display("%0t phase_now exp %0d got %0d", $realtime, v.ph, m_tdata[7:5]);
            fails++;
          end
          if (m_tdata[10:8] !== v.ch) begin
            $display("%0t channel_count exp %0d got %0d", $realtime, v.ch, m_tdata[10:8]);
            fails++;
          end
          if (m_tdata[11] !== v.start) begin
            $display("%0t image_data_start exp %b got %b", $realtime, v.start, m_tdata[11]);
            fails++;
          end
          if (m_tlast !== v.fin) begin
            $display("%0t stream_end exp %b got %b", $realtime, v.fin, m_tlast);
            fails++;
          end
        end
      end
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 7);
      m_tready <= !(hold_rx || (stall > 0 && !quiet));
    end
  end

  initial begin
    chunk_t c;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_rx   = 1'b0;
    quiet     = 1'b0;
    fails     = 0;
    mdl_limit = 40'd1073741824;
    mdl_phase = PH_WANT;
    mdl_seen  = '0;
    mdl_kind  = '0;
    mdl_depth = '0;
    mdl_chan  = '0;
    mdl_pal   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_limit(40'hFF_FFFF_FFFF);

    // indexed image, 8 bit, Adam7
    c = mk(T_IHDR, 31'd13);
    c.w = 32'd1; c.h = 32'd1; c.bd = 8'd8; c.ct = 8'd3;
    c.cmp = 8'd0; c.flt = 8'd0; c.il = 8'd1;
    add_row(c, 1, E_OK);
    add_row(mk(T_GAMA, 31'd4), 1, E_OK);
    add_row(mk(T_CHRM, 31'd32), 1, E_OK);
    add_row(mk(T_SRGB, 31'd1), 1, E_OK);
    add_row(mk(T_SBIT, 31'd3), 1, E_OK);
    add_row(mk(T_PLTE, 31'd768), 1, E_OK);
    // repeated palette replaces its size
    add_row(mk(T_PLTE, 31'd6), 0, E_OK);
    add_row(mk(T_TRNS, 31'd2), 0, E_OK);
    add_row(mk(T_HIST, 31'd2), 1, E_OK);
    add_row(mk(T_BKGD, 31'd1), 1, E_OK);
    add_row(mk(T_PHYS, 31'd9), 1, E_OK);
    add_row(mk(T_SPLT, 31'h7FFF_FFFF), 1, E_OK);
    add_row(mk(T_TEXT, 31'd2), 1, E_OK);
    add_row(mk(32'h7a7a7a7a, 31'd0), 1, E_OK);
    add_row(mk(T_IDAT, 31'd0), 1, E_OK);
    add_row(mk(T_IDAT, 31'h7FFF_FFFF), 1, E_OK);
    add_row(mk(T_ZTXT, 31'd3), 1, E_OK);
    add_row(mk(T_ITXT, 31'd6), 1, E_OK);
    add_row(mk(T_TIME, 31'd7), 1, E_OK);
    // ancillary header chunk is skipped once data has started
    add_row(mk(T_GAMA, 31'd0), 0, E_OK);
    foreach (dir_rows[i]) send_chunk(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].err);

    for (int part = 0; part < 4; part++) begin
      case (part)
        0: write_limit(40'd1);
        1: write_limit(40'd1073741824);
        2: write_limit(40'($urandom) | (40'($urandom_range(0, 255)) << 32) | 40'd1);
        default: write_limit(40'hFF_FFFF_FFFF);
      endcase
      if (part == 1) fork
        begin
          repeat (40) @(posedge clk);
          hold_rx <= 1'b1;
          repeat (300) @(posedge clk);
          hold_rx <= 1'b0;
        end
      join_none
      if (part == 3) quiet = 1'b1;
      for (int k = 0; k < 480; k++) send_chunk(data_chunk());
    end

    // stop the block: clean end or an unknown critical chunk
    if ($urandom_range(0, 1)) c = mk(T_IEND, 31'd0);
    else c = mk($urandom & ~(32'd1 << ANC_BIT), 31'($urandom));
    if (c.ctype == T_IDAT) c.ctype = T_IEND;
    if (c.ctype == T_IEND) c.len = 31'd0;
    send_chunk(c);
    for (int k = 0; k < 30; k++) send_chunk(mk($urandom, 31'($urandom)), 1, E_STOPPED);

    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
